// ===== rtl/bsm_pkg.sv =====
package bsm_pkg;

	localparam int CW     = 32;            // centre width
	localparam int RW     = 31;            // radius width
	localparam int DW     = CW + 1;        // centre difference / root / quotient width
	localparam int PW     = 2 * DW;        // product and radicand width
	localparam int REMW   = DW + 4;        // iterative unit remainder width
	localparam int STEPS  = DW;            // iterations of the shared unit
	localparam int CNTW   = $clog2(STEPS);

	localparam logic [RW-1:0] RAD_MAX = {RW{1'b1}};

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} iter_ctrl_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_SQ    = 10'b00_0000_0010,
		S_ACC   = 10'b00_0000_0100,
		S_RGO   = 10'b00_0000_1000,
		S_RWAIT = 10'b00_0001_0000,
		S_DEC   = 10'b00_0010_0000,
		S_MUL   = 10'b00_0100_0000,
		S_DGO   = 10'b00_1000_0000,
		S_DWAIT = 10'b01_0000_0000,
		S_FIN   = 10'b10_0000_0000
	} state_t;

endpackage

// ===== rtl/bsm_mul.sv =====
module bsm_mul (
	input  logic                         clk,
	input  logic [bsm_pkg::DW-1:0]       a,
	input  logic [bsm_pkg::DW-1:0]       b,
	output logic [bsm_pkg::PW-1:0]       p_s1
);
	import bsm_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= PW'(a) * PW'(b);
	end

endmodule

// ===== rtl/bsm_iter.sv =====
// Shared restoring unit: square root (two bits a step) or division (one bit a step).
module bsm_iter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bsm_pkg::iter_ctrl_t       ctrl,
	input  logic [bsm_pkg::PW-1:0]    operand,
	input  logic [bsm_pkg::DW-1:0]    divisor,
	output logic                      done,
	output logic [bsm_pkg::DW-1:0]    result
);
	import bsm_pkg::*;

	logic              busy_q, done_q, sqrt_q;
	logic [CNTW-1:0]   cnt_q;
	logic [REMW-1:0]   rem_q;
	logic [PW-1:0]     work_q;
	logic [DW-1:0]     res_q;
	logic [REMW-1:0]   r2, sub, nrem;
	logic              ge;

	always_comb begin
		if (sqrt_q) begin
			r2  = {rem_q[REMW-3:0], work_q[PW-1 -: 2]};
			sub = {2'b00, res_q, 2'b01};
		end else begin
			r2  = {rem_q[REMW-2:0], work_q[PW-1]};
			sub = {4'b0000, divisor};
		end
		ge   = r2 >= sub;
		nrem = ge ? r2 - sub : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(STEPS - 1));
			if (ctrl.start)
				busy_q <= 1'b1;
			else if (busy_q && (cnt_q == CNTW'(STEPS - 1)))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sqrt_q <= ctrl.is_sqrt;
			cnt_q  <= '0;
			res_q  <= '0;
			if (ctrl.is_sqrt) begin
				rem_q  <= '0;
				work_q <= operand;
			end else begin
				// quotient fits DW bits, so the top bits already sit below the divisor
				rem_q  <= {4'b0000, operand[PW-1 -: DW]};
				work_q <= {operand[DW-1:0], {DW{1'b0}}};
			end
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			rem_q  <= nrem;
			res_q  <= {res_q[DW-2:0], ge};
			work_q <= sqrt_q ? {work_q[PW-3:0], 2'b00} : {work_q[PW-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/bounding_sphere_merge.sv =====
// Running bounding sphere in signed fixed point (Q16.16 by default; the arithmetic works on
// raw integers and does not depend on the fraction width). A word with restart high loads
// its sphere as the held sphere; otherwise the sphere is merged into the held one, and
// each input word yields one output word with the held sphere after the update.
// saturated is set when the merged radius or a moved centre is clamped to its range. A
// restart word goes straight to the finish state. A merge ends after its square root when
// one sphere already holds the other or no centre move is needed, and when the centre
// moves it takes one 33-step square root and three 33-step divisions, all on one shared
// restoring unit, plus a registered multiplier used for the squares and the centre
// offsets. in_stall stays high from acceptance until the result sits in the output
// register; a finished result waits there while the next word is taken.
module bounding_sphere_merge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     restart,
	input  logic signed [31:0]       in_center_x,
	input  logic signed [31:0]       in_center_y,
	input  logic signed [31:0]       in_center_z,
	input  logic [30:0]              in_radius,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [31:0]       out_center_x,
	output logic signed [31:0]       out_center_y,
	output logic signed [31:0]       out_center_z,
	output logic [30:0]              out_radius,
	output logic                     saturated
);
	import bsm_pkg::*;

	state_t                        state_q;
	logic [1:0]                    ax_q;
	logic signed [2:0][CW-1:0]     held_c_q, in_c_q, nc_q;
	logic [RW-1:0]                 held_r_q, in_r_q, nr_q;
	logic                          sat_q;
	logic [PW-1:0]                 acc_q;
	logic [DW-1:0]                 d_q, half_q;
	logic                          out_valid_q;
	logic signed [2:0][CW-1:0]     out_c_q;
	logic [RW-1:0]                 out_r_q;
	logic                          out_sat_q;

	logic                          in_acc, out_free;
	logic signed [DW-1:0]          dh;
	logic [DW-1:0]                 adiff, mul_b;
	logic [PW-1:0]                 prod_s1;
	iter_ctrl_t                    ictl;
	logic                          idone;
	logic [DW-1:0]                 ires;
	logic                          held_large;
	logic [RW-1:0]                 lr, sr;
	logic [DW:0]                   sum, over;
	logic [DW-1:0]                 half;
	logic                          grow, move;
	logic [DW+1:0]                 nr_full;
	logic                          neg;
	logic signed [CW-1:0]          cl;
	logic signed [DW:0]            newc;
	logic signed [CW-1:0]          newc_cl;
	logic                          newc_sat;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	// difference of the held and input centres on the current axis
	assign dh    = DW'(signed'(held_c_q[ax_q])) - DW'(signed'(in_c_q[ax_q]));
	assign adiff = dh[DW-1] ? DW'(-dh) : DW'(dh);
	assign mul_b = (state_q == S_MUL) ? half_q : adiff;

	bsm_mul u_mul (
		.clk  (clk),
		.a    (adiff),
		.b    (mul_b),
		.p_s1 (prod_s1)
	);

	assign ictl.start   = (state_q == S_RGO) || (state_q == S_DGO);
	assign ictl.is_sqrt = state_q == S_RGO;

	bsm_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ictl),
		.operand ((state_q == S_RGO) ? acc_q : prod_s1),
		.divisor (d_q),
		.done    (idone),
		.result  (ires)
	);

	// merge decision: ties go to the input sphere
	always_comb begin
		held_large = held_r_q > in_r_q;
		lr   = held_large ? held_r_q : in_r_q;
		sr   = held_large ? in_r_q : held_r_q;
		sum  = {1'b0, d_q} + (DW+1)'(sr);
		grow = sum > (DW+1)'(lr);
		over = sum - (DW+1)'(lr);
		half = over[DW:1];
		move = d_q > half;
		nr_full = (DW+2)'(lr) + (move ? (DW+2)'(half) : (DW+2)'(over));
	end

	// step the large centre toward the small one by the quotient, clamped
	always_comb begin
		neg     = held_large ? !dh[DW-1] : dh[DW-1];
		cl      = held_large ? held_c_q[ax_q] : in_c_q[ax_q];
		newc    = neg ? (DW+1)'(cl) - (DW+1)'(ires) : (DW+1)'(cl) + (DW+1)'(ires);
		newc_sat = 1'b0;
		newc_cl  = CW'(newc);
		if (newc > (DW+1)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
			newc_cl  = {1'b0, {(CW-1){1'b1}}};
			newc_sat = 1'b1;
		end else if (newc < -(DW+1)'(signed'({1'b0, {(CW-1){1'b1}}})) - 1) begin
			newc_cl  = {1'b1, {(CW-1){1'b0}}};
			newc_sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
			held_c_q    <= '0;
			held_r_q    <= '0;
		end else begin
			// load the output word when finishing, drop it once taken
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					ax_q <= '0;
					if (in_acc)
						state_q <= restart ? S_FIN : S_SQ;
				end
				S_SQ:    state_q <= S_ACC;
				S_ACC: begin
					// advance to the next axis, then take the root
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
					state_q <= (ax_q == 2'd2) ? S_RGO : S_SQ;
				end
				S_RGO:   state_q <= S_RWAIT;
				S_RWAIT: if (idone) state_q <= S_DEC;
				S_DEC: begin
					ax_q    <= '0;
					state_q <= (grow && move) ? S_MUL : S_FIN;
				end
				S_MUL:   state_q <= S_DGO;
				S_DGO:   state_q <= S_DWAIT;
				S_DWAIT: begin
					if (idone) begin
						ax_q    <= ax_q + 1'b1;
						state_q <= (ax_q == 2'd2) ? S_FIN : S_MUL;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						held_c_q    <= nc_q;
						held_r_q    <= nr_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					in_c_q <= {in_center_z, in_center_y, in_center_x};
					in_r_q <= in_radius;
					nc_q   <= {in_center_z, in_center_y, in_center_x};
					nr_q   <= in_radius;
					sat_q  <= 1'b0;
					acc_q  <= '0;
				end
			end
			S_ACC:   acc_q <= acc_q + prod_s1;
			S_RWAIT: if (idone) d_q <= ires;
			S_DEC: begin
				nc_q   <= held_large ? held_c_q : in_c_q;
				half_q <= half;
				if (!grow) begin
					nr_q <= lr;
				end else if (nr_full > (DW+2)'(RAD_MAX)) begin
					nr_q  <= RAD_MAX;
					sat_q <= 1'b1;
				end else begin
					nr_q <= RW'(nr_full);
				end
			end
			S_DWAIT: begin
				if (idone) begin
					nc_q[ax_q] <= newc_cl;
					if (newc_sat)
						sat_q <= 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_c_q   <= nc_q;
					out_r_q   <= nr_q;
					out_sat_q <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_center_x = out_c_q[0];
	assign out_center_y = out_c_q[1];
	assign out_center_z = out_c_q[2];
	assign out_radius   = out_r_q;
	assign saturated    = out_sat_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted word left the sequencer idle");
	a_done_where: assert property (@(posedge clk) disable iff (!arst_n)
		idone |-> (state_q == S_RWAIT || state_q == S_DWAIT))
		else $error("shared unit finished outside a wait state");
	a_sat_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> out_radius == RAD_MAX)
		else $error("saturated word without clamped radius");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_FIN)
		else $error("output word loaded outside the finish state");

endmodule

// ===== tb/sphere_checker.sv =====
`timescale 1ns / 1ps

module sphere_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               restart,
	input  logic signed [31:0] in_center_x,
	input  logic signed [31:0] in_center_y,
	input  logic signed [31:0] in_center_z,
	input  logic [30:0]        in_radius,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_center_x,
	input  logic signed [31:0] out_center_y,
	input  logic signed [31:0] out_center_z,
	input  logic [30:0]        out_radius,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending,
	output int                 clamp_count
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        r;
		logic               sat;
	} sphere_t;

	sphere_t held;
	sphere_t merged_spheres[$];
	int      n_pred;
	int      n_seen;

	// floor of the square root of a sum of three squares (below 2^67)
	function automatic logic [33:0] root_of(input logic [67:0] v);
		logic [33:0] root;
		logic [33:0] cand;
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			cand = root | (34'd1 << b);
			if ({36'd0, cand} * {36'd0, cand} <= {2'd0, v})
				root = cand;
		end
		return root;
	endfunction

	function automatic logic signed [31:0] clamp_centre(input logic signed [71:0] v,
			inout logic sat);
		if (v > 72'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -72'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] shift_toward(input logic signed [31:0] cl,
			input logic signed [31:0] cs, input logic [33:0] half, input logic [33:0] d,
			inout logic sat);
		logic signed [71:0] diff;
		logic [71:0] mag;
		logic [71:0] q;
		diff = 72'(cs) - 72'(cl);
		mag  = diff < 0 ? 72'(-diff) : 72'(diff);
		q    = (mag * {38'd0, half}) / {38'd0, d};
		return clamp_centre(diff < 0 ? 72'(cl) - $signed(q) : 72'(cl) + $signed(q), sat);
	endfunction

	function automatic sphere_t merge_sphere(input sphere_t h, input sphere_t s);
		logic signed [33:0] dx, dy, dz;
		logic [67:0] sum;
		logic [33:0] d, over, half;
		sphere_t lg, sm, res;
		logic [35:0] nr;
		logic sat;
		dx  = 34'(h.x) - 34'(s.x);
		dy  = 34'(h.y) - 34'(s.y);
		dz  = 34'(h.z) - 34'(s.z);
		// squares of 34-bit signed values fit in 68 bits unsigned
		sum = 68'($unsigned(68'(dx) * 68'(dx))) + 68'($unsigned(68'(dy) * 68'(dy)))
			+ 68'($unsigned(68'(dz) * 68'(dz)));
		d   = root_of(sum);
		if (h.r > s.r) begin
			lg = h; sm = s;
		end else begin
			lg = s; sm = h;
		end
		res = lg;
		sat = 1'b0;
		if ({2'd0, d} + 36'(sm.r) > 36'(lg.r)) begin
			over = 34'({2'd0, d} + 36'(sm.r) - 36'(lg.r));
			half = over >> 1;
			if (d > half) begin
				nr    = 36'(lg.r) + 36'(half);
				res.x = shift_toward(lg.x, sm.x, half, d, sat);
				res.y = shift_toward(lg.y, sm.y, half, d, sat);
				res.z = shift_toward(lg.z, sm.z, half, d, sat);
			end else begin
				nr = 36'(lg.r) + 36'(over);
			end
			if (nr > 36'h7fffffff) begin
				nr  = 36'h7fffffff;
				sat = 1'b1;
			end
			res.r = nr[30:0];
		end
		res.sat = sat;
		return res;
	endfunction

	// predict on every accepted input word
	always @(posedge clk or negedge arst_n) begin
		sphere_t s, res;
		if (!arst_n) begin
			held <= '0;
			merged_spheres.delete();
			clamp_count <= 0;
			n_pred <= 0;
		end else if (in_valid && !in_stall) begin
			s = '{in_center_x, in_center_y, in_center_z, in_radius, 1'b0};
			res = restart ? s : merge_sphere(held, s);
			if (res.sat)
				clamp_count <= clamp_count + 1;
			held <= res;
			merged_spheres.push_back(res);
			n_pred <= n_pred + 1;
		end
	end

	// compare every accepted output word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		sphere_t e;
		if (!arst_n) begin
			n_seen <= 0;
		end else if (out_valid && !out_stall) begin
			if (merged_spheres.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d z=%0d r=%0d sat=%0b", $time,
					out_center_x, out_center_y, out_center_z, out_radius, saturated);
				fail_count++;
			end else begin
				e = merged_spheres.pop_front();
				n_seen <= n_seen + 1;
				if (out_center_x !== e.x || out_center_y !== e.y || out_center_z !== e.z
						|| out_radius !== e.r || saturated !== e.sat) begin
					$display("%0t: expected x=%0d y=%0d z=%0d r=%0d sat=%0b", $time,
						e.x, e.y, e.z, e.r, e.sat);
					$display("%0t: actual   x=%0d y=%0d z=%0d r=%0d sat=%0b", $time,
						out_center_x, out_center_y, out_center_z, out_radius, saturated);
					fail_count++;
				end
			end
		end
	end

	assign pending = n_pred - n_seen;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               restart;
	logic signed [31:0] in_center_x;
	logic signed [31:0] in_center_y;
	logic signed [31:0] in_center_z;
	logic [30:0]        in_radius;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] out_center_x;
	logic signed [31:0] out_center_y;
	logic signed [31:0] out_center_z;
	logic [30:0]        out_radius;
	logic               saturated;

	int fail_count;
	int pending;
	int clamp_count;
	int burst_left;
	int restarts_sent;
	int merges_sent;

	localparam logic [30:0] RMAX = 31'h7fffffff;
	localparam int          RANDOM_WORDS = 1800;

	bounding_sphere_merge dut (.*);

	sphere_checker chk (.*);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: pick a stall mode now and then - never, sometimes, often, or in long runs
	initial begin
		int mode;
		int left;
		out_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 400);
			end
			left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 85);
				default: out_stall <= (left % 64) < 40;
			endcase
		end
	end

	// hold the word until the block takes it; return at a falling edge with valid still high
	task automatic send_sphere(input logic rs, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z, input logic [30:0] r);
		if (burst_left == 0) begin
			// idle gap between bursts, sometimes none
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid    <= 1'b1;
		restart     <= rs;
		in_center_x <= x;
		in_center_y <= y;
		in_center_z <= z;
		in_radius   <= r;
		do @(posedge clk); while (in_stall);
		if (rs) restarts_sent++;
		else merges_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_centre(input int span);
		case (span)
			0: return $signed($urandom_range(0, 2000)) - 1000;
			1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_radius(input int span);
		case (span)
			0: return 31'($urandom_range(0, 1500));
			1: return 31'($urandom_range(0, 1 << 22));
			2: return RMAX - 31'($urandom_range(0, 1 << 20));
			default: return 31'($urandom);
		endcase
	endfunction

	initial begin
		int span;
		int chain;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		restart     = 1'b0;
		in_center_x = '0;
		in_center_y = '0;
		in_center_z = '0;
		in_radius   = '0;
		burst_left  = 0;
		restarts_sent = 0;
		merges_sent   = 0;
		chain         = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: merge with the zero sphere straight after reset
		send_sphere(1'b0, 32'sd65536, -32'sd131072, 32'sd3, 31'd70000);
		// extreme restart, then a far opposite point that overflows the radius
		send_sphere(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, RMAX);
		send_sphere(1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'd0);
		send_sphere(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd0);
		send_sphere(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'd0);
		// contained sphere leaves the held one unchanged
		send_sphere(1'b1, 32'sd0, 32'sd0, 32'sd0, 31'd1000);
		send_sphere(1'b0, 32'sd10, 32'sd0, 32'sd0, 31'd100);
		// input encloses the held sphere
		send_sphere(1'b0, 32'sd5, 32'sd0, 32'sd0, 31'd100000);
		// equal radii apart, then a smaller sphere at the same input centre
		send_sphere(1'b1, 32'sd0, 32'sd0, 32'sd0, 31'd100);
		send_sphere(1'b0, 32'sd1000, -32'sd500, 32'sd0, 31'd100);
		send_sphere(1'b0, 32'sd1000, -32'sd500, 32'sd0, 31'd99);
		// centres one apart, equal radii: smallest excess
		send_sphere(1'b1, 32'sd7, 32'sd7, 32'sd7, 31'd50);
		send_sphere(1'b0, 32'sd8, 32'sd7, 32'sd7, 31'd50);
		// merge with a huge sphere near the clamp
		send_sphere(1'b0, -32'sd1000000, 32'sd0, 32'sd2000000, RMAX - 31'd10);
		send_sphere(1'b0, 32'sd2000000, 32'sd9, -32'sd5, 31'd12345);
		send_sphere(1'b1, 32'sd0, 32'sd0, 32'sd0, 31'd0);
		send_sphere(1'b0, 32'sd0, 32'sd0, 32'sd0, 31'd0);

		// random: mostly a restart then a chain of merges of one scale, plus some noise
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				// drain everything before carrying on
				in_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			if (chain == 0) begin
				span  = $urandom_range(0, 9) < 7 ? $urandom_range(0, 1) : $urandom_range(2, 3);
				chain = $urandom_range(1, 12);
				send_sphere($urandom_range(0, 9) != 0, pick_centre(span), pick_centre(span),
					pick_centre(span), pick_radius(span));
			end else begin
				chain--;
				send_sphere($urandom_range(0, 19) == 0, pick_centre(span), pick_centre(span),
					pick_centre(span), $urandom_range(0, 29) == 0 ? pick_radius(2)
					: pick_radius(span));
			end
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (300) @(posedge clk);
		$display("Sent %0d restart and %0d merge words; %0d results clamped.",
			restarts_sent, merges_sent, clamp_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
